[rtl/square_matrix_multiply_core_macros.svh]
// assertion macros for the square matrix multiply core checker
// no dependencies; included by the checker file only
`ifndef SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smm check failed");

// consequent checked in the cycle after the antecedent
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smm check failed");

`endif

[rtl/smm_pkg.sv]
// shared types and constants of the square matrix multiply core
// no dependencies; imported by the cell, the top level and the checker
package smm_pkg;

    // sizes fixed by the item fields
    localparam int C_MAX_DIM = 8;
    localparam int C_VAL_W   = 10;
    localparam int C_PROD_W  = 2 * C_VAL_W;
    localparam int C_SUM_W   = 23;
    localparam int C_IDX_W   = 3;
    localparam int C_DIM_W   = 4;

    // input item: one element pair
    typedef struct packed {
        logic [C_VAL_W-1:0] a_value;
        logic [C_VAL_W-1:0] b_value;
        logic               last_pair;
    } t_smm_in;

    // result item: one product element
    typedef struct packed {
        logic [C_SUM_W-1:0] product_value;
        logic [C_IDX_W-1:0] out_row;
        logic [C_IDX_W-1:0] out_col;
        logic               last_result;
    } t_smm_out;

    // token handed from cell to cell: one element of A with its position
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic [C_IDX_W-1:0] k;
        logic [C_IDX_W-1:0] row;
        logic [C_VAL_W-1:0] a;
    } t_smm_tok;

    // broadcast write of one B element into its column cell
    typedef struct packed {
        logic               en;
        logic [C_IDX_W-1:0] row;
        logic [C_IDX_W-1:0] col;
        logic [C_VAL_W-1:0] data;
    } t_smm_bwr;

    // finished sum from one cell
    typedef struct packed {
        logic               valid;
        logic [C_SUM_W-1:0] value;
        logic [C_IDX_W-1:0] row;
    } t_smm_cres;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BLOAD,
        ST_FEED,
        ST_DRAIN
    } t_smm_state;

endpackage

[rtl/smm_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module smm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/smm_cell.sv]
// multiply-accumulate cell: holds one column of B, sums A row times that column
// depends on smm_pkg
module smm_cell import smm_pkg::*; #(
    parameter int MAX_DIM = C_MAX_DIM,
    parameter int COL     = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_smm_tok  i_tok,
    output t_smm_tok  o_tok,
    input  t_smm_bwr  i_bwr,
    input  logic      i_active,
    output t_smm_cres o_res
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [C_VAL_W-1:0]  r_bcol [MAX_DIM];
    t_smm_tok            r_tok;
    logic                r_pv;
    logic                r_pfirst;
    logic                r_plast;
    logic [C_IDX_W-1:0]  r_prow;
    logic [C_PROD_W-1:0] r_prod;
    logic                r_done;
    logic [C_IDX_W-1:0]  r_drow;
    logic [C_SUM_W-1:0]  r_acc;
    logic [C_VAL_W-1:0]  b_sel;

    // column storage, written while loading
    always_ff @(posedge i_clk) begin
        if (i_bwr.en && (i_bwr.col == C_IDX_W'(COL))) begin
            r_bcol[i_bwr.row[IW-1:0]] <= i_bwr.data;
        end
    end

    assign b_sel = r_bcol[r_tok.k[IW-1:0]];

    // control: token stage, product valid, done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_tok  <= i_tok;
            r_pv   <= r_tok.valid && i_active;
            r_done <= r_pv && r_plast;
        end
    end

    // payload: product then running sum
    always_ff @(posedge i_clk) begin
        r_prod   <= r_tok.a * b_sel;
        r_pfirst <= r_tok.first;
        r_plast  <= r_tok.last;
        r_prow   <= r_tok.row;
        r_drow   <= r_prow;
        if (r_pv) begin
            if (r_pfirst) begin
                r_acc <= C_SUM_W'(r_prod);
            end else begin
                r_acc <= r_acc + C_SUM_W'(r_prod);
            end
        end
    end

    assign o_tok = r_tok;
    assign o_res = '{valid: r_done, value: r_acc, row: r_drow};

endmodule

[rtl/square_matrix_multiply_core.sv]
// top level of the square matrix multiply core: load control, A and B stores, cell chain
// depends on smm_pkg, smm_ram, smm_cell
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------
//  input     | start, busy           | i_item (t_smm_in)
//  result    | o_strobe (one cycle)  | o_result (t_smm_out)
//  config    | i_cfg_we              | i_cfg_data (dimension)
//
// loading takes one item per cycle while busy is low.
// the item flagged last raises busy: first B is copied from its store into the column
// cells, then A is fed one element per cycle into the chain, of which d cells are active,
// then the results drain through the chain and the output register.
// results come out one per cycle, row-major; busy drops as the last one shows.
// the receiver cannot stall; synchronous reset clears control only, stores hold no reset value.
module square_matrix_multiply_core import smm_pkg::*; #(
    parameter int MAX_DIM = C_MAX_DIM
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_smm_in            i_item,
    output logic               o_strobe,
    output t_smm_out           o_result,
    input  logic               i_cfg_we,
    input  logic [C_DIM_W-1:0] i_cfg_data
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = $clog2(MAX_DIM + 1);

    t_smm_state          r_state;
    t_smm_state          n_state;
    logic [DW-1:0]       r_dim;
    logic [CW-1:0]       r_ld_idx;
    logic [AW-1:0]       r_bl_addr;
    logic [IW-1:0]       r_bl_row;
    logic [IW-1:0]       r_bl_col;
    logic                r_bl_en;
    logic [IW-1:0]       r_bl_wrow;
    logic [IW-1:0]       r_bl_wcol;
    logic [AW-1:0]       r_fd_addr;
    logic [IW-1:0]       r_fd_k;
    logic [IW-1:0]       r_fd_i;
    t_smm_tok            r_tag;
    logic                r_out_vld;
    t_smm_out            r_out;

    logic [CW-1:0]       cells;
    logic [IW-1:0]       dim_m1;
    logic                accept;
    logic                store;
    logic                bload;
    logic                bload_end;
    logic                feed;
    logic                feed_end;
    logic [C_VAL_W-1:0]  ram_q;
    logic [C_VAL_W-1:0]  b_ram_q;
    t_smm_bwr            bwr;
    t_smm_tok            w_tok [MAX_DIM];
    t_smm_cres           w_res [MAX_DIM];
    logic                sel_valid;
    logic [C_SUM_W-1:0]  sel_value;
    logic [C_IDX_W-1:0]  sel_row;
    logic [C_IDX_W-1:0]  sel_col;
    logic                sel_last;

    assign cells     = CW'(r_dim) * CW'(r_dim);
    assign dim_m1    = IW'(r_dim - DW'(1));
    assign accept    = start && !busy;
    assign store     = accept && (r_ld_idx < cells);
    assign bload     = (r_state == ST_BLOAD);
    assign bload_end = bload && (r_bl_row == dim_m1) && (r_bl_col == dim_m1);
    assign feed      = (r_state == ST_FEED);
    assign feed_end  = feed && (r_fd_k == dim_m1) && (r_fd_i == dim_m1);
    assign busy      = (r_state != ST_IDLE);

    // dimension register, clamped to 1..MAX_DIM as it is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DW'(MAX_DIM);
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                r_dim <= DW'(1);
            end else if (i_cfg_data > C_DIM_W'(MAX_DIM)) begin
                r_dim <= DW'(MAX_DIM);
            end else begin
                r_dim <= DW'(i_cfg_data);
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_item.last_pair) begin
                    n_state = ST_BLOAD;
                end
            end
            ST_BLOAD: begin
                if (bload_end) begin
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                if (feed_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (sel_valid && sel_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // load position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_idx <= '0;
        end else if (accept && i_item.last_pair) begin
            r_ld_idx <= '0;
        end else if (store) begin
            r_ld_idx <= r_ld_idx + CW'(1);
        end
    end

    // B copy counters walk the B store row-major; each cell write comes in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bl_addr <= '0;
            r_bl_row  <= '0;
            r_bl_col  <= '0;
            r_bl_en   <= 1'b0;
            r_bl_wrow <= '0;
            r_bl_wcol <= '0;
        end else begin
            r_bl_en   <= bload;
            r_bl_wrow <= r_bl_row;
            r_bl_wcol <= r_bl_col;
            if (!bload) begin
                r_bl_addr <= '0;
                r_bl_row  <= '0;
                r_bl_col  <= '0;
            end else begin
                r_bl_addr <= r_bl_addr + AW'(1);
                if (r_bl_col == dim_m1) begin
                    r_bl_col <= '0;
                    r_bl_row <= r_bl_row + IW'(1);
                end else begin
                    r_bl_col <= r_bl_col + IW'(1);
                end
            end
        end
    end

    // feed counters walk A row-major, one element per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fd_addr <= '0;
            r_fd_k    <= '0;
            r_fd_i    <= '0;
            r_tag     <= '0;
        end else begin
            r_tag.valid <= feed;
            r_tag.first <= (r_fd_k == '0);
            r_tag.last  <= (r_fd_k == dim_m1);
            r_tag.k     <= C_IDX_W'(r_fd_k);
            r_tag.row   <= C_IDX_W'(r_fd_i);
            r_tag.a     <= '0;
            if (!feed) begin
                r_fd_addr <= '0;
                r_fd_k    <= '0;
                r_fd_i    <= '0;
            end else begin
                r_fd_addr <= r_fd_addr + AW'(1);
                if (r_fd_k == dim_m1) begin
                    r_fd_k <= '0;
                    r_fd_i <= r_fd_i + IW'(1);
                end else begin
                    r_fd_k <= r_fd_k + IW'(1);
                end
            end
        end
    end

    // A store
    smm_ram #(
        .WIDTH (C_VAL_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_ld_idx[AW-1:0]),
        .i_wdata (i_item.a_value),
        .i_raddr (r_fd_addr),
        .o_rdata (ram_q)
    );

    // B store, kept by row-major position
    smm_ram #(
        .WIDTH (C_VAL_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_ld_idx[AW-1:0]),
        .i_wdata (i_item.b_value),
        .i_raddr (r_bl_addr),
        .o_rdata (b_ram_q)
    );

    // B element read back goes to the cell of its column
    assign bwr = '{en: r_bl_en, row: C_IDX_W'(r_bl_wrow), col: C_IDX_W'(r_bl_wcol),
                   data: b_ram_q};

    // head of the chain: store read data joined with its position tag
    always_comb begin
        w_tok[0]   = r_tag;
        w_tok[0].a = ram_q;
    end

    // chain of cells, one per column
    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        if (g == MAX_DIM - 1) begin : g_tail
            smm_cell #(
                .MAX_DIM (MAX_DIM),
                .COL     (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tok    (w_tok[g]),
                .o_tok    (),
                .i_bwr    (bwr),
                .i_active (DW'(g) < r_dim),
                .o_res    (w_res[g])
            );
        end else begin : g_mid
            smm_cell #(
                .MAX_DIM (MAX_DIM),
                .COL     (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tok    (w_tok[g]),
                .o_tok    (w_tok[g+1]),
                .i_bwr    (bwr),
                .i_active (DW'(g) < r_dim),
                .o_res    (w_res[g])
            );
        end
    end

    // at most one cell finishes per cycle: pick it
    always_comb begin
        sel_valid = 1'b0;
        sel_value = '0;
        sel_row   = '0;
        sel_col   = '0;
        for (int j = 0; j < MAX_DIM; j++) begin
            if (w_res[j].valid) begin
                sel_valid = 1'b1;
                sel_value = w_res[j].value;
                sel_row   = w_res[j].row;
                sel_col   = C_IDX_W'(j);
            end
        end
        sel_last = (sel_row == C_IDX_W'(dim_m1)) && (sel_col == C_IDX_W'(dim_m1));
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= sel_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= '{product_value: sel_value, out_row: sel_row, out_col: sel_col,
                   last_result: sel_last};
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule

[rtl/smm_chk.sv]
// port-level checks of the square matrix multiply core, bound to the top level
// depends on smm_pkg and square_matrix_multiply_core_macros.svh
`include "square_matrix_multiply_core_macros.svh"

module smm_chk import smm_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_smm_in  i_item,
    input logic     o_strobe,
    input t_smm_out o_result
);

    // the item flagged last starts a run
    `SMM_ASSERT_NEXT(a_run_starts, i_clk, i_rst_n, start && !busy && i_item.last_pair, busy)

    // every result but the final one shows while busy
    `SMM_ASSERT_SAME(a_res_in_run, i_clk, i_rst_n, o_strobe && !o_result.last_result, busy)

    // busy drops only together with the final result
    `SMM_ASSERT_SAME(a_end_on_last, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_strobe && o_result.last_result)

    // nothing follows the final result directly
    `SMM_ASSERT_NEXT(a_quiet_after, i_clk, i_rst_n, o_strobe && o_result.last_result, !o_strobe)

    // the final result sits on the diagonal corner
    `SMM_ASSERT_SAME(a_last_corner, i_clk, i_rst_n, o_strobe && o_result.last_result, o_result.out_row == o_result.out_col)

endmodule

bind square_matrix_multiply_core smm_chk u_smm_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
